// File: rtl/core/bb3_pkg.sv
// package for the 3x3 box blur: sizes, shared types and rounding helpers
// no dependencies
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 4096;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int FwW       = 11;
    localparam int FhW       = 13;
    localparam int QDepth    = 8;
    localparam int QAw       = $clog2(QDepth);

    localparam logic [1:0] RegFrameWidth  = 2'd0;
    localparam logic [1:0] RegFrameHeight = 2'd1;

    // front to back: one window advance
    typedef struct packed {
        logic [23:0]     pixel;
        logic [23:0]     col_top;
        logic [23:0]     col_mid;
        logic            emit;
        logic            last;
        logic            top_ok;
        logic            bot_ok;
        logic            left_ok;
        logic            right_ok;
    } t_cmd;

    // back pipeline payload
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_res;

    localparam int ResW = $bits(t_res);

    // rounded mean, sum up to 9*255, n one of 1, 2, 3, 4, 6 or 9
    function automatic logic [7:0] div_round(input logic [11:0] sum, input logic [3:0] n);
        logic [23:0] p;
        begin
            p = '0;
            case (n)
                4'd4:    p = {12'd0, (sum + 12'd2) >> 2};
                4'd6:    p = ({12'd0, sum + 12'd3} * 24'd2731) >> 14;
                4'd9:    p = ({12'd0, sum + 12'd4} * 24'd7282) >> 16;
                4'd1:    p = {12'd0, sum};
                4'd2:    p = {12'd0, (sum + 12'd1) >> 1};
                4'd3:    p = ({12'd0, sum + 12'd1} * 24'd5462) >> 14;
                default: p = '0;
            endcase
            return p[7:0];
        end
    endfunction

endpackage

// File: rtl/core/bb3_front.sv
// front part: frame counters, line stores, window column fetch
// depends on bb3_pkg
`timescale 1ns / 1ps

module bb3_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [bb3_pkg::ColW:0]       i_w,
    input  logic [bb3_pkg::RowW:0]       i_h,
    input  logic                         i_push,
    input  logic                         i_req_type,
    input  logic [23:0]                  i_pixel,
    input  logic                         i_q_full,
    output logic                         o_full,
    output logic                         o_take,
    output logic                         o_cmd_valid,
    output bb3_pkg::t_cmd                o_cmd
);

    logic [23:0] r_prev  [bb3_pkg::MaxWidth];
    logic [23:0] r_prev2 [bb3_pkg::MaxWidth];

    logic [bb3_pkg::ColW-1:0] r_ci, n_ci, r_oc, n_oc;
    logic [bb3_pkg::RowW:0]   r_ri, n_ri;
    logic [bb3_pkg::RowW-1:0] r_or, n_or;
    logic [23:0] w_pix;
    logic        w_in_frame, w_take, w_emit, w_last;
    logic [23:0] r_top_raw, r_mid_q, r_byp_d;
    logic        r_byp, r_p2_we;
    logic [bb3_pkg::ColW-1:0] r_p2_col;

    assign o_full     = i_q_full;
    assign o_take     = w_take;
    assign w_in_frame = r_ri < i_h;
    assign w_take     = i_push && !i_q_full && !(w_in_frame && i_req_type);
    assign w_pix      = w_in_frame ? i_pixel : 24'd0;
    assign w_emit     = (r_ri >= 2) || (r_ri == 1 && r_ci >= 1);
    assign w_last     = ({1'b0, r_or} >= i_h - 1) && ({1'b0, r_oc} >= i_w - 1);

    always_comb begin
        n_ci = r_ci + 1'b1;
        n_ri = r_ri;
        n_oc = r_oc;
        n_or = r_or;
        if ({1'b0, n_ci} >= i_w || n_ci == '0) begin
            n_ci = '0;
            n_ri = r_ri + 1'b1;
        end
        if (w_emit) begin
            if (w_last) begin
                n_ci = '0; n_ri = '0; n_oc = '0; n_or = '0;
            end else begin
                n_oc = r_oc + 1'b1;
                if ({1'b0, n_oc} >= i_w || n_oc == '0) begin
                    n_oc = '0;
                    n_or = r_or + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ci <= '0; r_ri <= '0; r_oc <= '0; r_or <= '0;
        end else if (w_take) begin
            r_ci <= n_ci; r_ri <= n_ri; r_oc <= n_oc; r_or <= n_or;
        end
    end

    // line stores: registered reads; the older store takes the middle row in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_top_raw    <= r_prev2[r_ci];
            r_mid_q      <= r_prev[r_ci];
            r_byp        <= r_p2_we && (r_p2_col == r_ci);
            r_byp_d      <= r_mid_q;
            r_p2_col     <= r_ci;
            r_prev[r_ci] <= w_pix;
        end
        if (r_p2_we) begin
            r_prev2[r_p2_col] <= r_mid_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_we <= 1'b0;
        end else begin
            r_p2_we <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cmd_valid <= 1'b0;
        end else begin
            o_cmd_valid <= w_take;
        end
    end

    bb3_pkg::t_cmd r_cmd;
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.pixel    <= w_pix;
            r_cmd.emit     <= w_emit;
            r_cmd.last     <= w_last;
            r_cmd.top_ok   <= r_or != '0;
            r_cmd.bot_ok   <= {1'b0, r_or} < i_h - 1;
            r_cmd.left_ok  <= r_oc != '0;
            r_cmd.right_ok <= {1'b0, r_oc} < i_w - 1;
            r_cmd.col_top  <= '0;
            r_cmd.col_mid  <= '0;
        end
    end

    // a pending older-store write to the same column bypasses the store
    always_comb begin
        o_cmd         = r_cmd;
        o_cmd.col_top = r_byp ? r_byp_d : r_top_raw;
        o_cmd.col_mid = r_mid_q;
    end

endmodule

// File: rtl/core/bb3_fifo.sv
// small synchronous queue of fixed depth for result words
// depends on bb3_pkg
`timescale 1ns / 1ps

module bb3_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic [bb3_pkg::ResW-1:0] i_data,
    input  logic                     i_rd,
    output logic                     o_empty,
    output logic                     o_full,
    output logic [bb3_pkg::ResW-1:0] o_data
);

    logic [bb3_pkg::ResW-1:0] r_mem [bb3_pkg::QDepth];
    logic [bb3_pkg::QAw:0]    r_wp, r_rp;

    assign o_empty = r_wp == r_rp;
    assign o_full  = (r_wp[bb3_pkg::QAw] != r_rp[bb3_pkg::QAw]) &&
                     (r_wp[bb3_pkg::QAw-1:0] == r_rp[bb3_pkg::QAw-1:0]);
    assign o_data  = r_mem[r_rp[bb3_pkg::QAw-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp[bb3_pkg::QAw-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_wr && !o_full)  r_wp <= r_wp + 1'b1;
            if (i_rd && !o_empty) r_rp <= r_rp + 1'b1;
        end
    end

endmodule

// File: rtl/core/bb3_back.sv
// back part: 3x3 window, masked sums, rounding divide
// depends on bb3_pkg
`timescale 1ns / 1ps

module bb3_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bb3_pkg::t_cmd        i_cmd,
    output logic                 o_valid,
    output bb3_pkg::t_res        o_res
);

    logic [23:0] r_win [3][3];
    logic [11:0] w_sum [3];
    logic [3:0]  w_n;
    logic        w_rok [3];
    logic        w_cok [3];
    logic [11:0] r_sum [3];
    logic [3:0]  r_n;
    logic        r_v, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) r_win[r][c] <= '0;
        end else if (i_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_cmd.col_top;
            r_win[1][2] <= i_cmd.col_mid;
            r_win[2][2] <= i_cmd.pixel;
        end
    end

    // window as it stands after this shift
    always_comb begin
        logic [23:0] nw [3][3];
        for (int r = 0; r < 3; r++) begin
            nw[r][0] = r_win[r][1];
            nw[r][1] = r_win[r][2];
        end
        nw[0][2] = i_cmd.col_top;
        nw[1][2] = i_cmd.col_mid;
        nw[2][2] = i_cmd.pixel;
        w_rok[0] = i_cmd.top_ok;  w_rok[1] = 1'b1; w_rok[2] = i_cmd.bot_ok;
        w_cok[0] = i_cmd.left_ok; w_cok[1] = 1'b1; w_cok[2] = i_cmd.right_ok;
        w_n = 4'd0;
        for (int k = 0; k < 3; k++) w_sum[k] = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (w_rok[r] && w_cok[c]) begin
                    w_n = w_n + 4'd1;
                    for (int k = 0; k < 3; k++)
                        w_sum[k] = w_sum[k] + {4'd0, nw[r][c][(2-k)*8 +: 8]};
                end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid && i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= w_sum;
        r_n    <= w_n;
        r_last <= i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.red   <= bb3_pkg::div_round(r_sum[0], r_n);
        o_res.green <= bb3_pkg::div_round(r_sum[1], r_n);
        o_res.blue  <= bb3_pkg::div_round(r_sum[2], r_n);
        o_res.last  <= r_last;
    end

endmodule

// File: rtl/core/box_blur_3x3_edge_aware_top.sv
// top level of the streaming 3x3 box blur
// a word with a result passes the command register, the sum register and the result register, then enters the queue
// throughput: one word per cycle; push is held off only when 8 words hold credit,
// which happens only while results wait for pop
// output lags input by one row plus one pixel; flush words drain the frame
// reset: synchronous active low, counters, window and control registers return to
// defaults; line stores are not cleared (never-written entries are masked)
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_end_of_frame
);

    logic [bb3_pkg::FwW-1:0] r_fw;
    logic [bb3_pkg::FhW-1:0] r_fh;
    logic                    w_wr, w_qfull, w_cv, w_bv, w_rfull;
    logic [bb3_pkg::ColW:0]  w_w;
    logic [bb3_pkg::RowW:0]  w_h;
    bb3_pkg::t_cmd           w_cmd;
    bb3_pkg::t_res           w_res, w_qo;
    logic [bb3_pkg::QAw+1:0] r_inflight;
    logic                    w_ftake;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 11'd640;
            r_fh <= 13'd480;
        end else if (w_wr) begin
            if (paddr[2] == bb3_pkg::RegFrameWidth[0])  r_fw <= pwdata[bb3_pkg::FwW-1:0];
            if (paddr[2] == bb3_pkg::RegFrameHeight[0]) r_fh <= pwdata[bb3_pkg::FhW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2]) prdata[bb3_pkg::FhW-1:0] = r_fh;
        else          prdata[bb3_pkg::FwW-1:0] = r_fw;
    end

    // clamp sizes to 2..max
    assign w_w = (r_fw < 11'd2) ? 11'd2
               : (r_fw > 11'(bb3_pkg::MaxWidth)) ? 11'(bb3_pkg::MaxWidth)
               : r_fw[bb3_pkg::ColW:0];
    assign w_h = (r_fh < 13'd2) ? 13'd2
               : (r_fh > 13'(bb3_pkg::MaxHeight)) ? 13'(bb3_pkg::MaxHeight)
               : r_fh[bb3_pkg::RowW:0];

    // credit: words in flight plus queued must fit the queue
    // dropped flush words take no credit, words without a result return it in the cycle after they are taken
    assign w_qfull = ({1'b0, r_inflight} >= bb3_pkg::QDepth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + (w_ftake ? 1'b1 : 1'b0)
                        - ((pop && !empty) ? 1'b1 : 1'b0)
                        - ((w_cv && !w_cmd.emit) ? 1'b1 : 1'b0);
        end
    end

    bb3_front u_front (
        .i_clk, .i_rst_n, .i_restart(w_wr), .i_w(w_w), .i_h(w_h),
        .i_push(push), .i_req_type, .i_pixel({i_in_red, i_in_green, i_in_blue}),
        .i_q_full(w_qfull), .o_full(full), .o_take(w_ftake), .o_cmd_valid(w_cv),
        .o_cmd(w_cmd)
    );

    bb3_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_cv), .i_cmd(w_cmd), .o_valid(w_bv), .o_res(w_res)
    );

    bb3_fifo u_q (
        .i_clk, .i_rst_n, .i_wr(w_bv), .i_data(w_res), .i_rd(pop),
        .o_empty(empty), .o_full(w_rfull), .o_data(w_qo)
    );

    assign o_out_red      = w_qo.red;
    assign o_out_green    = w_qo.green;
    assign o_out_blue     = w_qo.blue;
    assign o_end_of_frame = w_qo.last;

    // result queue never overflows, full only on credit exhaustion, a word written to an empty queue shows next cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_bv && w_rfull)) else $error("result queue overflow");
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_qfull) else $error("full without credit exhaustion");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bv && empty) |=> !empty) else $error("result lost");

endmodule
